// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the bit-to-symbol mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, suspended while rst is high.
`define BTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds on a rising edge of clk outside reset.
`define BTS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: src/bts_pkg.sv
// Types, constants and the group-size decoder of the bit-to-symbol mapper.
package bts_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned WIDTH_W   = 4;
  localparam int unsigned ACC_W     = 16;
  localparam int unsigned HELD_W    = 4;
  localparam int unsigned GRP_W     = 3;
  localparam int unsigned MAX_ORDER = 8;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(2);
  localparam logic [GRP_W-1:0]   GRP_NONE    = GRP_W'(0);
  localparam logic [GRP_W-1:0]   GRP_THREE   = GRP_W'(3);
  localparam logic [GRP_W-1:0]   GRP_FOUR    = GRP_W'(4);

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cfg_wr;
    logic load;
    logic pad;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic sym_avail;
    logic item_err;
    logic is_last;
  } sts_t;

  // Bytes per group for a symbol width; GRP_NONE marks a width that fits no group
  function automatic logic [GRP_W-1:0] group_bytes(input logic [WIDTH_W-1:0] w);
    logic [GRP_W-1:0] g;
    if (32'(w) > MAX_ORDER) begin
      g = GRP_NONE;
    end else begin
      unique case (w) inside
        WIDTH_W'(1), WIDTH_W'(2), WIDTH_W'(4), WIDTH_W'(8): g = GRP_FOUR;
        WIDTH_W'(3), WIDTH_W'(6):                           g = GRP_THREE;
        default:                                            g = GRP_NONE;
      endcase
    end
    return g;
  endfunction

endpackage

// File: src/bts_in_if.sv
// Byte input channel: valid/ready handshake carrying one stream byte.
interface bts_in_if;
  logic                        valid;
  logic                        ready;
  logic [bts_pkg::BYTE_W-1:0]  data_byte;
  logic                        end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// File: src/bts_out_if.sv
// Symbol output channel: valid/ready handshake carrying one symbol word.
interface bts_out_if;
  logic                        valid;
  logic                        ready;
  logic [bts_pkg::SYM_W-1:0]   symbol_index;
  logic                        last_of_run;
  logic                        stream_done;
  logic                        config_error;

  modport source (output valid, output symbol_index, output last_of_run,
                  output stream_done, output config_error, input ready);
  modport sink   (input valid, input symbol_index, input last_of_run,
                  input stream_done, input config_error, output ready);
endinterface

// File: src/bts_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying the symbol width.
interface bts_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bts_pkg::WIDTH_W-1:0]  bits_per_symbol;

  modport source (output valid, output bits_per_symbol, input ready);
  modport sink   (input valid, input bits_per_symbol, output ready);
endinterface

// File: src/bit_to_symbol_mapper.sv
// Top level of the bit-to-symbol mapper: channel wiring of controller and datapath.
//
// Bytes arrive on byte_in and are cut MSB first into symbols of bits_per_symbol bits
// (reset value 2), delivered one word per symbol on sym_out. Widths 1, 2, 4 and 8 work
// on groups of four bytes, widths 3 and 6 on groups of three; bits left over from a byte
// carry into the next byte of its group and no symbol crosses a group boundary. A byte
// with end_of_stream set closes the stream: its group is padded with zero bytes, every
// remaining symbol is sent, and the accumulator starts afresh. last_of_run marks the
// final word caused by a byte and stream_done the final word of a stream. Any other
// width gives one word per byte with config_error set and symbol_index zero. Writing
// cfg discards a partial group; cfg is taken only while no byte is in flight, and it
// takes precedence over a byte offered in the same cycle. One byte is handled at a
// time: the byte is accepted, then the single output register is loaded with one
// symbol per cycle while the sink takes words, and a zero byte is padded into the
// group in place of a symbol where an ended stream still lacks bits. An error byte
// gives its single word. The output register lets the next byte enter while the
// last word is still waiting.
module bit_to_symbol_mapper (
  input  logic        clk,
  input  logic        rst,
  bts_in_if.sink      byte_in,
  bts_out_if.source   sym_out,
  bts_cfg_if.sink     cfg
);

  bts_pkg::cmd_t cmd;
  bts_pkg::sts_t sts;

  // Sequence accept, padding and symbol emission
  bts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_in.valid),
    .cfg_valid (cfg.valid),
    .sts       (sts),
    .in_ready  (byte_in.ready),
    .cfg_ready (cfg.ready),
    .cmd       (cmd)
  );

  // Hold the bit accumulator, group counters and the output word
  bts_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .data_byte     (byte_in.data_byte),
    .end_of_stream (byte_in.end_of_stream),
    .cfg_width     (cfg.bits_per_symbol),
    .out_ready     (sym_out.ready),
    .out_valid     (sym_out.valid),
    .symbol_index  (sym_out.symbol_index),
    .last_of_run   (sym_out.last_of_run),
    .stream_done   (sym_out.stream_done),
    .config_error  (sym_out.config_error)
  );

endmodule

// File: src/bts_ctrl.sv
// Controller state machine of the bit-to-symbol mapper.
`include "assert_macros.svh"

module bts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          cfg_valid,
  input  bts_pkg::sts_t sts,
  output logic          in_ready,
  output logic          cfg_ready,
  output bts_pkg::cmd_t cmd
);

  bts_pkg::state_t state;
  bts_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bts_pkg::ST_IDLE: begin
        if (in_valid && !cfg_valid) begin
          state_next = bts_pkg::ST_BUSY;
        end
      end
      bts_pkg::ST_BUSY: begin
        if (sts.out_free && (sts.item_err || sts.sym_avail) && sts.is_last) begin
          state_next = bts_pkg::ST_IDLE;
        end
      end
      default: state_next = bts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    cmd       = '0;
    unique case (state)
      bts_pkg::ST_IDLE: begin
        // configuration wins over a byte offered in the same cycle
        cfg_ready  = 1'b1;
        in_ready   = !cfg_valid;
        cmd.cfg_wr = cfg_valid;
        cmd.load   = in_valid && !cfg_valid;
      end
      bts_pkg::ST_BUSY: begin
        cmd.pad  = !sts.item_err && !sts.sym_avail;
        cmd.emit = sts.out_free && (sts.item_err || sts.sym_avail);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `BTS_ASSERT(a_emit_needs_slot, cmd.emit |-> sts.out_free, "symbol emitted into a full output register")
  `BTS_ASSERT(a_load_goes_busy, cmd.load |=> (state == bts_pkg::ST_BUSY) && !in_ready, "byte accepted without entering busy")
  `BTS_ASSERT_NEVER(a_pad_and_emit, cmd.pad && cmd.emit, "pad and emit issued together")

endmodule

// File: src/bts_dpath.sv
// Datapath of the bit-to-symbol mapper: accumulator, counters and output register.
`include "assert_macros.svh"

module bts_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  bts_pkg::cmd_t                 cmd,
  output bts_pkg::sts_t                 sts,
  input  logic [bts_pkg::BYTE_W-1:0]    data_byte,
  input  logic                          end_of_stream,
  input  logic [bts_pkg::WIDTH_W-1:0]   cfg_width,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [bts_pkg::SYM_W-1:0]     symbol_index,
  output logic                          last_of_run,
  output logic                          stream_done,
  output logic                          config_error
);

  logic [bts_pkg::WIDTH_W-1:0] width;
  logic [bts_pkg::ACC_W-1:0]   acc;
  logic [bts_pkg::HELD_W-1:0]  held;
  logic [bts_pkg::GRP_W-1:0]   bytes;
  logic                        eos;
  logic                        err;

  logic [bts_pkg::GRP_W-1:0]   grp;
  logic [bts_pkg::HELD_W-1:0]  held_after;
  logic [bts_pkg::ACC_W-1:0]   shifted;
  logic [bts_pkg::SYM_W:0]     mask_wide;
  logic [bts_pkg::SYM_W-1:0]   sym;
  logic                        more_pad;
  logic                        grp_done;
  logic                        is_last;

  assign grp        = bts_pkg::group_bytes(width);
  assign held_after = held - width;
  assign shifted    = acc >> held_after;
  assign mask_wide  = ((bts_pkg::SYM_W+1)'(1) << width) - (bts_pkg::SYM_W+1)'(1);
  assign sym        = bts_pkg::SYM_W'(shifted) & mask_wide[bts_pkg::SYM_W-1:0];
  assign more_pad   = eos && (bytes < grp);
  assign grp_done   = bytes >= grp;
  assign is_last    = err || ((held_after < width) && !more_pad);

  assign sts.out_free  = !out_valid || out_ready;
  assign sts.sym_avail = held >= width;
  assign sts.item_err  = err;
  assign sts.is_last   = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      width <= bts_pkg::WIDTH_RESET;
      acc   <= '0;
      held  <= '0;
      bytes <= '0;
      eos   <= 1'b0;
      err   <= 1'b0;
    end else begin
      if (cmd.cfg_wr) begin
        width <= cfg_width;
        acc   <= '0;
        held  <= '0;
        bytes <= '0;
      end
      if (cmd.load) begin
        eos <= end_of_stream;
        err <= (grp == bts_pkg::GRP_NONE);
        if (grp != bts_pkg::GRP_NONE) begin
          acc   <= {acc[bts_pkg::ACC_W-bts_pkg::BYTE_W-1:0], data_byte};
          held  <= held + bts_pkg::HELD_W'(bts_pkg::BYTE_W);
          bytes <= bytes + bts_pkg::GRP_W'(1);
        end
      end
      if (cmd.pad) begin
        acc   <= {acc[bts_pkg::ACC_W-bts_pkg::BYTE_W-1:0], bts_pkg::BYTE_W'(0)};
        held  <= held + bts_pkg::HELD_W'(bts_pkg::BYTE_W);
        bytes <= bytes + bts_pkg::GRP_W'(1);
      end
      if (cmd.emit) begin
        if (err) begin
          if (eos) begin
            acc   <= '0;
            held  <= '0;
            bytes <= '0;
          end
        end else if (is_last && (eos || grp_done)) begin
          acc   <= '0;
          held  <= '0;
          bytes <= '0;
        end else begin
          held <= held_after;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      symbol_index <= err ? '0 : sym;
      last_of_run  <= is_last;
      stream_done  <= is_last && eos;
      config_error <= err;
    end
  end

  `BTS_ASSERT(a_group_bound, (grp == bts_pkg::GRP_NONE) || (bytes <= grp), "byte count ran past the group size")
  `BTS_ASSERT(a_flush_clears, (cmd.emit && is_last && eos) |=> (held == '0) && (bytes == '0), "state not cleared after end of stream")
  `BTS_ASSERT(a_err_word, (cmd.emit && err) |=> out_valid && last_of_run && config_error, "error word not delivered as a single last word")

endmodule
